// File: rtl/dtpb_pkg.sv
// ----------------------------------------------------------------------------
// dtpb_pkg
// Shared types, widths and register codes for the depth-to-point
// back-projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package dtpb_pkg;

    // Field and datapath widths
    localparam int DEPTH_W  = 16;
    localparam int DIM_W    = 13;
    localparam int CENTER_W = 20;
    localparam int INV_W    = 24;
    localparam int HALF_W   = 12;               // inverse focal length split in halves
    localparam int COORD_W  = 32;
    localparam int DIFF_W   = 24;               // |pos*256 - center| for MAX_DIM up to 65536
    localparam int MAG_W    = DIFF_W + DEPTH_W; // diff * depth
    localparam int PROD_W   = MAG_W + HALF_W;   // one partial product
    localparam int Q_W      = MAG_W + 1;        // rounded magnitude in Q.8
    localparam int FRAC_SH  = 24;               // Q.32 to Q.8
    localparam int QUEUE_DEPTH = 4;

    localparam int MAX_DIM_DEF = 4096;

    // Register indexes (byte address bits [4:2])
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CENTER_X     = 3'd2;
    localparam logic [2:0] REG_CENTER_Y     = 3'd3;
    localparam logic [2:0] REG_INV_FOCAL_X  = 3'd4;
    localparam logic [2:0] REG_INV_FOCAL_Y  = 3'd5;

    // Register reset values
    localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 13'd400;
    localparam logic [CENTER_W-1:0] RST_CENTER_X     = 20'd82941;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 20'd51424;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X  = 24'd41943;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y  = 24'd41943;

    // Saturation limits
    localparam logic [COORD_W-1:0] SAT_POS_VAL = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_NEG_VAL = 32'h8000_0000;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               frame_start;
    } t_pixel;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic                      last_in_frame;
        logic                      saturated;
    } t_point;

    typedef struct packed {
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
    } t_cfg;

    // Classified pixel handed from the front end to the back end
    typedef struct packed {
        logic               last;
        logic [DEPTH_W-1:0] depth;
        logic               neg_x;
        logic [DIFF_W-1:0]  diff_x;
        logic               neg_y;
        logic [DIFF_W-1:0]  diff_y;
    } t_job;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

// File: rtl/depth_to_point_backprojection.sv
// ----------------------------------------------------------------------------
// depth_to_point_backprojection
// Pinhole back-projection of a raster depth stream into 3D points.
// ----------------------------------------------------------------------------
// Each accepted depth pixel yields one point (x, y, z) in raster order. The
// front end takes a pixel in any cycle the four-entry queue has room, so
// short bursts enter at one per clock; sustained, the block delivers one
// point per pass of the back-end sequencer, which steps each axis through
// depth scaling, two 12-bit partial products with the inverse focal length
// on a per-axis shared multiplier, rounding and saturation. The
// output register lets the next point be computed while one waits to be
// taken. frame_start forces the pixel to column 0, row 0; without it the
// counters wrap at the configured width and height. Configure only while no
// pixel is in flight. No clearing pass is needed after reset.
`default_nettype none

module depth_to_point_backprojection #(
    parameter int MAX_DIM = dtpb_pkg::MAX_DIM_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Pixel input
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire dtpb_pkg::t_pixel i_pixel,
    // Point output
    output logic                  o_valid,
    input  wire logic             i_ready,
    output dtpb_pkg::t_point      o_point,
    // Configuration
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    dtpb_pkg::t_cfg   r_cfg;
    dtpb_pkg::t_job   push_job;
    dtpb_pkg::t_job   head_job;
    dtpb_pkg::t_qstat qstat;
    logic             push;
    logic             pop;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= dtpb_pkg::RST_IMAGE_WIDTH;
            r_cfg.image_height <= dtpb_pkg::RST_IMAGE_HEIGHT;
            r_cfg.center_x     <= dtpb_pkg::RST_CENTER_X;
            r_cfg.center_y     <= dtpb_pkg::RST_CENTER_Y;
            r_cfg.inv_focal_x  <= dtpb_pkg::RST_INV_FOCAL_X;
            r_cfg.inv_focal_y  <= dtpb_pkg::RST_INV_FOCAL_Y;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                dtpb_pkg::REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[dtpb_pkg::DIM_W-1:0];
                dtpb_pkg::REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[dtpb_pkg::DIM_W-1:0];
                dtpb_pkg::REG_CENTER_X:     r_cfg.center_x     <= pwdata[dtpb_pkg::CENTER_W-1:0];
                dtpb_pkg::REG_CENTER_Y:     r_cfg.center_y     <= pwdata[dtpb_pkg::CENTER_W-1:0];
                dtpb_pkg::REG_INV_FOCAL_X:  r_cfg.inv_focal_x  <= pwdata[dtpb_pkg::INV_W-1:0];
                dtpb_pkg::REG_INV_FOCAL_Y:  r_cfg.inv_focal_y  <= pwdata[dtpb_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (paddr[4:2])
            dtpb_pkg::REG_IMAGE_WIDTH:  prdata = 32'(r_cfg.image_width);
            dtpb_pkg::REG_IMAGE_HEIGHT: prdata = 32'(r_cfg.image_height);
            dtpb_pkg::REG_CENTER_X:     prdata = 32'(r_cfg.center_x);
            dtpb_pkg::REG_CENTER_Y:     prdata = 32'(r_cfg.center_y);
            dtpb_pkg::REG_INV_FOCAL_X:  prdata = 32'(r_cfg.inv_focal_x);
            dtpb_pkg::REG_INV_FOCAL_Y:  prdata = 32'(r_cfg.inv_focal_y);
            default:                    prdata = '0;
        endcase
    end

    dtpb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_ready (o_ready),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (push_job)
    );

    dtpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_stat  (qstat)
    );

    dtpb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_qstat (qstat),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_point (o_point)
    );

    // A saturated point carries a clipped coordinate on at least one axis
    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_point.saturated |->
            (o_point.point_x == dtpb_pkg::SAT_POS_VAL) ||
            (o_point.point_x == dtpb_pkg::SAT_NEG_VAL) ||
            (o_point.point_y == dtpb_pkg::SAT_POS_VAL) ||
            (o_point.point_y == dtpb_pkg::SAT_NEG_VAL))
        else $error("saturated flag without a clipped coordinate");

    // An accepted pixel is held in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !qstat.empty)
        else $error("accepted pixel missing from queue");

    // The front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("push into full queue");

endmodule

`default_nettype wire

// File: rtl/dtpb_queue.sv
// ----------------------------------------------------------------------------
// dtpb_queue
// Small flop-based FIFO of classified pixels between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpb_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire dtpb_pkg::t_job  i_data,
    input  wire logic            i_pop,
    output dtpb_pkg::t_job       o_data,
    output dtpb_pkg::t_qstat     o_stat
);

    localparam int DEPTH = dtpb_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    dtpb_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [AW:0]    r_count;
    logic           do_push;
    logic           do_pop;

    // Drop pushes into a full queue and pops from an empty one
    assign do_push = i_push && (r_count != (AW+1)'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (AW+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

// File: rtl/dtpb_front.sv
// ----------------------------------------------------------------------------
// dtpb_front
// Accepts depth pixels, tracks raster position and classifies each pixel
// into sign and magnitude of its offsets from the principal point.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpb_front #(
    parameter int MAX_DIM = dtpb_pkg::MAX_DIM_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dtpb_pkg::t_cfg   i_cfg,
    input  wire logic             i_valid,
    input  wire dtpb_pkg::t_pixel i_pixel,
    output logic                  o_ready,
    input  wire dtpb_pkg::t_qstat i_qstat,
    output logic                  o_push,
    output dtpb_pkg::t_job        o_job
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = (CW + 1 > dtpb_pkg::DIM_W) ? CW + 1 : dtpb_pkg::DIM_W;

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic [EW-1:0] w_eff;
    logic [EW-1:0] h_eff;
    logic [EW-1:0] col_inc;
    logic [EW-1:0] row_inc;
    logic          row_end;
    logic          col_end;

    // Clamp a dimension register to [1, MAX_DIM]
    function automatic logic [EW-1:0] eff_dim(input logic [dtpb_pkg::DIM_W-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        if (ext == '0) begin
            return EW'(1);
        end else if (ext > EW'(MAX_DIM)) begin
            return EW'(MAX_DIM);
        end
        return ext;
    endfunction

    // Split pos*256 - center into sign and magnitude
    function automatic logic [dtpb_pkg::DIFF_W:0] classify(
        input logic [CW-1:0]                 pos,
        input logic [dtpb_pkg::CENTER_W-1:0] center
    );
        logic [dtpb_pkg::DIFF_W-1:0] p;
        logic [dtpb_pkg::DIFF_W-1:0] c;
        p = dtpb_pkg::DIFF_W'({pos, 8'h00});
        c = dtpb_pkg::DIFF_W'(center);
        if (p < c) begin
            return {1'b1, c - p};
        end
        return {1'b0, p - c};
    endfunction

    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    // Position of this pixel and end-of-row / end-of-frame checks
    always_comb begin
        w_eff   = eff_dim(i_cfg.image_width);
        h_eff   = eff_dim(i_cfg.image_height);
        col     = i_pixel.frame_start ? '0 : r_col;
        row     = i_pixel.frame_start ? '0 : r_row;
        col_inc = EW'(col) + EW'(1);
        row_inc = EW'(row) + EW'(1);
        row_end = (col_inc >= w_eff);
        col_end = (row_inc >= h_eff);
        if (row_end) begin
            n_col = '0;
            n_row = col_end ? '0 : row_inc[CW-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = row;
        end
    end

    // Build the job for the back end
    always_comb begin
        o_job.last                 = row_end && col_end;
        o_job.depth                = i_pixel.depth;
        {o_job.neg_x, o_job.diff_x} = classify(col, i_cfg.center_x);
        {o_job.neg_y, o_job.diff_y} = classify(row, i_cfg.center_y);
    end

    // Advance raster counters per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dtpb_back.sv
// ----------------------------------------------------------------------------
// dtpb_back
// Sequencer that scales each queued pixel by depth and inverse focal length,
// rounds to Q.8, saturates and presents the point in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpb_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dtpb_pkg::t_cfg   i_cfg,
    input  wire dtpb_pkg::t_qstat i_qstat,
    input  wire dtpb_pkg::t_job   i_job,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output dtpb_pkg::t_point      o_point
);

    localparam int MAG_W  = dtpb_pkg::MAG_W;
    localparam int PROD_W = dtpb_pkg::PROD_W;
    localparam int HALF_W = dtpb_pkg::HALF_W;
    localparam int Q_W    = dtpb_pkg::Q_W;
    localparam int CW     = dtpb_pkg::COORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HI,
        S_LO,
        S_FIN,
        S_SAT
    } t_state;

    t_state                       r_state;
    logic [MAG_W-1:0]             r_mag   [2];
    logic [PROD_W-1:0]            r_a     [2];
    logic [PROD_W-1:0]            r_b     [2];
    logic [Q_W-1:0]               r_q     [2];
    logic                         r_neg   [2];
    logic [dtpb_pkg::DEPTH_W-1:0] r_depth;
    logic                         r_last;
    logic                         r_out_valid;
    dtpb_pkg::t_point             r_point;

    logic [dtpb_pkg::INV_W-1:0]   inv      [2];
    logic [dtpb_pkg::DIFF_W-1:0]  diff     [2];
    logic                         neg_in   [2];
    logic [HALF_W-1:0]            mult_in  [2];
    logic [PROD_W-1:0]            prod     [2];
    logic [MAG_W-1:0]             mag_new  [2];
    logic [PROD_W:0]              lo_sum   [2];
    logic [Q_W-1:0]               q_new    [2];
    logic                         sat      [2];
    logic [CW-1:0]                coord    [2];
    logic                         out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_qstat.empty;

    // Per-axis datapath: one shared multiplier walks the partial products
    always_comb begin
        inv[0]    = i_cfg.inv_focal_x;
        inv[1]    = i_cfg.inv_focal_y;
        diff[0]   = i_job.diff_x;
        diff[1]   = i_job.diff_y;
        neg_in[0] = i_job.neg_x;
        neg_in[1] = i_job.neg_y;
        for (int i = 0; i < 2; i++) begin
            mag_new[i] = MAG_W'(diff[i]) * MAG_W'(i_job.depth);
            mult_in[i] = (r_state == S_HI) ? inv[i][2*HALF_W-1:HALF_W]
                                           : inv[i][HALF_W-1:0];
            prod[i]    = PROD_W'(r_mag[i]) * PROD_W'(mult_in[i]);
            // Round half away from zero: (a*2^12 + b + 2^23) >> 24
            lo_sum[i]  = (PROD_W+1)'({r_a[i][HALF_W-1:0], {HALF_W{1'b0}}})
                       + (PROD_W+1)'(r_b[i])
                       + (PROD_W+1)'(1 << (dtpb_pkg::FRAC_SH - 1));
            q_new[i]   = Q_W'(r_a[i][PROD_W-1:HALF_W])
                       + Q_W'(lo_sum[i][PROD_W:dtpb_pkg::FRAC_SH]);
            // Clip the magnitude, then apply the sign
            if (r_neg[i]) begin
                sat[i]   = (r_q[i] > Q_W'(dtpb_pkg::SAT_NEG_VAL));
                coord[i] = sat[i] ? dtpb_pkg::SAT_NEG_VAL : (CW'(0) - r_q[i][CW-1:0]);
            end else begin
                sat[i]   = (r_q[i] > Q_W'(dtpb_pkg::SAT_POS_VAL));
                coord[i] = sat[i] ? dtpb_pkg::SAT_POS_VAL : r_q[i][CW-1:0];
            end
        end
    end

    // Sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the point once taken, unless a new one replaces it
            if (r_out_valid && i_ready && (r_state != S_SAT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        for (int i = 0; i < 2; i++) begin
                            r_mag[i] <= mag_new[i];
                            r_neg[i] <= neg_in[i];
                        end
                        r_depth <= i_job.depth;
                        r_last  <= i_job.last;
                        r_state <= S_HI;
                    end
                end
                S_HI: begin
                    for (int i = 0; i < 2; i++) begin
                        r_a[i] <= prod[i];
                    end
                    r_state <= S_LO;
                end
                S_LO: begin
                    for (int i = 0; i < 2; i++) begin
                        r_b[i] <= prod[i];
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    for (int i = 0; i < 2; i++) begin
                        r_q[i] <= q_new[i];
                    end
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    // Hand off once the output register is free
                    if (out_free) begin
                        r_point.point_x       <= coord[0];
                        r_point.point_y       <= coord[1];
                        r_point.point_z       <= r_depth;
                        r_point.last_in_frame <= r_last;
                        r_point.saturated     <= sat[0] || sat[1];
                        r_out_valid           <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_point = r_point;

endmodule

`default_nettype wire

// File: tb/sv/tb_depth_to_point_backprojection.sv
// ----------------------------------------------------------------------------
// tb_depth_to_point_backprojection
// Self-checking testbench for the depth-to-point back-projection block.
// ----------------------------------------------------------------------------
// Streams depth pixels through the valid/ready input, predicts every point
// with a fixed-point back-projection model kept in step with the register
// file, and compares each point taken from the output field by field. A
// short directed part covers reset values, saturation, zero focal
// reciprocals, dimension clamping, counters left past a shrunk dimension and
// unmapped registers. Random frames follow under changing configurations,
// with random bursts of idling on both sides and a final stretch without.
// ----------------------------------------------------------------------------
module tb_depth_to_point_backprojection;
    timeunit 1ns;
    timeprecision 1ps;

    import dtpb_pkg::*;

    // Register slots past the mapped ones
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // Frame styles used by the random stream
    localparam int FRAME_CUT      = 0;
    localparam int FRAME_NO_START = 1;
    localparam int FRAME_NOISY    = 2;

    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 40;
    localparam int FRAME_CAP     = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_pixel      i_pixel;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_point      o_point;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the register file and raster position
    logic [DIM_W-1:0]    cfg_width;
    logic [DIM_W-1:0]    cfg_height;
    logic [CENTER_W-1:0] cfg_center_x;
    logic [CENTER_W-1:0] cfg_center_y;
    logic [INV_W-1:0]    cfg_inv_x;
    logic [INV_W-1:0]    cfg_inv_y;
    int unsigned         col_pos;
    int unsigned         row_pos;

    t_point expected_points[$];
    int     mismatch_count = 0;
    int     points_seen = 0;
    int     tx_gap_pct = 0;
    int     rx_stall_pct = 0;
    int     rx_hold = 0;

    depth_to_point_backprojection dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_point (o_point),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] dim);
        if (dim == 0) return 1;
        if (dim > MAX_DIM_DEF) return MAX_DIM_DEF;
        return 32'(dim);
    endfunction

    // Scale the signed offset (pos - center) by depth and 1/f, round the
    // magnitude half away from zero to Q.8, then clip to signed 32 bits.
    function automatic logic [COORD_W-1:0] project_axis(
        input  int unsigned         pos,
        input  logic [CENTER_W-1:0] center,
        input  logic [DEPTH_W-1:0]  depth,
        input  logic [INV_W-1:0]    inv,
        output bit                  clipped
    );
        logic [63:0] scaled_pos;
        logic [63:0] offset;
        logic [63:0] mag;
        bit          below;
        clipped    = 1'b0;
        scaled_pos = 64'(pos) << 8;
        below      = scaled_pos < 64'(center);
        offset     = below ? 64'(center) - scaled_pos : scaled_pos - 64'(center);
        mag        = (offset * 64'(depth) * 64'(inv) + 64'h80_0000) >> FRAC_SH;
        if (below) begin
            if (mag > 64'h8000_0000) begin
                clipped = 1'b1;
                mag     = 64'h8000_0000;
            end
            return 32'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF) begin
            clipped = 1'b1;
            mag     = 64'h7FFF_FFFF;
        end
        return 32'(mag);
    endfunction

    // Turn one pixel into its point and advance the raster position.
    function automatic t_point backproject_pixel(input t_pixel pix);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        bit          row_end;
        bit          clip_x;
        bit          clip_y;
        t_point      pt;
        w       = clamp_dim(cfg_width);
        h       = clamp_dim(cfg_height);
        col     = pix.frame_start ? 0 : col_pos;
        row     = pix.frame_start ? 0 : row_pos;
        row_end = col + 1 >= w;
        pt.point_x       = project_axis(col, cfg_center_x, pix.depth, cfg_inv_x, clip_x);
        pt.point_y       = project_axis(row, cfg_center_y, pix.depth, cfg_inv_y, clip_y);
        pt.point_z       = pix.depth;
        pt.last_in_frame = row_end && (row + 1 >= h);
        pt.saturated     = clip_x | clip_y;
        if (row_end) begin
            col_pos = 0;
            row_pos = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col_pos = col + 1;
            row_pos = row;
        end
        return pt;
    endfunction

    function automatic logic [31:0] register_value(input logic [2:0] idx);
        case (idx)
            REG_IMAGE_WIDTH:  return 32'(cfg_width);
            REG_IMAGE_HEIGHT: return 32'(cfg_height);
            REG_CENTER_X:     return 32'(cfg_center_x);
            REG_CENTER_Y:     return 32'(cfg_center_y);
            REG_INV_FOCAL_X:  return 32'(cfg_inv_x);
            REG_INV_FOCAL_Y:  return 32'(cfg_inv_y);
            default:          return 32'd0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Compare every point taken from the output with the oldest prediction
    always @(posedge i_clk) begin : check_points
        t_point want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_points.size() == 0) begin
                report_error($sformatf("point %0d arrived with none expected", points_seen));
            end else begin
                want = expected_points.pop_front();
                if (o_point.point_x !== want.point_x) begin
                    report_error($sformatf("point %0d x: got %0d, want %0d",
                                           points_seen, o_point.point_x, want.point_x));
                end
                if (o_point.point_y !== want.point_y) begin
                    report_error($sformatf("point %0d y: got %0d, want %0d",
                                           points_seen, o_point.point_y, want.point_y));
                end
                if (o_point.point_z !== want.point_z) begin
                    report_error($sformatf("point %0d z: got %0d, want %0d",
                                           points_seen, o_point.point_z, want.point_z));
                end
                if (o_point.last_in_frame !== want.last_in_frame) begin
                    report_error($sformatf("point %0d last_in_frame: got %b, want %b",
                                           points_seen, o_point.last_in_frame,
                                           want.last_in_frame));
                end
                if (o_point.saturated !== want.saturated) begin
                    report_error($sformatf("point %0d saturated: got %b, want %b",
                                           points_seen, o_point.saturated, want.saturated));
                end
            end
            points_seen++;
        end
    end

    // Stall the output side in random bursts
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_ready <= 1'b0;
        end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            rx_hold = $urandom_range(0, 6);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one pixel, hold it until the transaction completes, and log
    // the predicted point. Starts and returns at a falling edge.
    task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic start);
        t_pixel pix;
        pix.depth       = depth;
        pix.frame_start = start;
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (!o_ready);
        expected_points.insert(expected_points.size(), backproject_pixel(pix));
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every predicted point has been taken
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width    = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height   = data[DIM_W-1:0];
            REG_CENTER_X:     cfg_center_x = data[CENTER_W-1:0];
            REG_CENTER_Y:     cfg_center_y = data[CENTER_W-1:0];
            REG_INV_FOCAL_X:  cfg_inv_x    = data[INV_W-1:0];
            REG_INV_FOCAL_Y:  cfg_inv_y    = data[INV_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Read back every mapped register and compare with the predictor copy
    task automatic check_registers();
        logic [31:0] got;
        for (int r = REG_IMAGE_WIDTH; r <= REG_INV_FOCAL_Y; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {3'(r), 2'b00};
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            got = prdata;
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge i_clk);
            if (got !== register_value(3'(r))) begin
                report_error($sformatf("register %0d reads %h, want %h",
                                       r, got, register_value(3'(r))));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Fill the bits above a register's width with junk
    function automatic logic [31:0] with_noise(input logic [31:0] value, input int width);
        return (32'($urandom) << width) | value;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(input int typical);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 13'd1;
            2:       return 13'($urandom_range(MAX_DIM_DEF + 1, 8191));
            3:       return 13'(MAX_DIM_DEF);
            default: return 13'($urandom_range(2, typical));
        endcase
    endfunction

    function automatic logic [CENTER_W-1:0] pick_center(input logic [DIM_W-1:0] dim);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 20'($urandom);
            default: return 20'($urandom_range(0, clamp_dim(dim) * 256));
        endcase
    endfunction

    function automatic logic [INV_W-1:0] pick_inv();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(1, 300000));
        endcase
    endfunction

    function automatic logic [DEPTH_W-1:0] pick_depth(input int floor_val);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom_range(floor_val, 65535));
        endcase
    endfunction

    task automatic load_random_config();
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        w  = pick_dim(16);
        h  = pick_dim(12);
        cx = pick_center(w);
        cy = pick_center(h);
        cfg_write(REG_IMAGE_WIDTH,  with_noise(32'(w), DIM_W));
        cfg_write(REG_IMAGE_HEIGHT, with_noise(32'(h), DIM_W));
        cfg_write(REG_CENTER_X,     with_noise(32'(cx), CENTER_W));
        cfg_write(REG_CENTER_Y,     with_noise(32'(cy), CENTER_W));
        cfg_write(REG_INV_FOCAL_X,  with_noise(32'(pick_inv()), INV_W));
        cfg_write(REG_INV_FOCAL_Y,  with_noise(32'(pick_inv()), INV_W));
        check_registers();
    endtask

    // Send whole frames with random depths; now and then cut a frame
    // short, drop its start mark or sprinkle stray start marks.
    task automatic stream_frames(input int count, input int depth_floor);
        int   sent;
        int   frame_len;
        int   style;
        logic start;
        sent = 0;
        while (sent < count) begin
            frame_len = clamp_dim(cfg_width) * clamp_dim(cfg_height);
            if (frame_len > FRAME_CAP) frame_len = FRAME_CAP;
            if (frame_len > count - sent) frame_len = count - sent;
            style = $urandom_range(0, 9);
            if (style == FRAME_CUT) frame_len = $urandom_range(1, frame_len);
            for (int i = 0; i < frame_len; i++) begin
                start = (i == 0) && (style != FRAME_NO_START);
                if (style == FRAME_NOISY && $urandom_range(0, 15) == 0) start = 1'b1;
                send_pixel(pick_depth(depth_floor), start);
                sent++;
                if ($urandom_range(0, 199) == 0) wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_values();
        check_registers();
        send_pixel(16'd0, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h5A5A, 1'b0);
    endtask

    // Far-off principal column with the largest reciprocal clips x; a zero
    // vertical reciprocal pins y to zero.
    task automatic test_saturation_and_zero_focal();
        wait_drained();
        cfg_write(REG_IMAGE_WIDTH,  32'd3);
        cfg_write(REG_IMAGE_HEIGHT, 32'd2);
        cfg_write(REG_CENTER_X,     32'h000F_FFFF);
        cfg_write(REG_CENTER_Y,     32'd0);
        cfg_write(REG_INV_FOCAL_X,  32'h00FF_FFFF);
        cfg_write(REG_INV_FOCAL_Y,  32'd0);
        check_registers();
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'd1, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'd0, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
    endtask

    // Zero dimensions act as one, oversize ones as the maximum
    task automatic test_dimension_clamp();
        wait_drained();
        cfg_write(REG_IMAGE_WIDTH,  32'hFFFF_E000);
        cfg_write(REG_IMAGE_HEIGHT, 32'd8191);
        cfg_write(REG_CENTER_X,     32'd0);
        cfg_write(REG_CENTER_Y,     32'd300);
        cfg_write(REG_INV_FOCAL_X,  32'd41943);
        cfg_write(REG_INV_FOCAL_Y,  32'h00FF_FFFF);
        send_pixel(16'd1000, 1'b1);
        send_pixel(16'd2000, 1'b0);
        send_pixel(16'd3000, 1'b0);
        wait_drained();
        cfg_write(REG_IMAGE_WIDTH,  32'd8191);
        cfg_write(REG_IMAGE_HEIGHT, 32'hFFFF_E000);
        check_registers();
        send_pixel(16'd4000, 1'b1);
        send_pixel(16'd5000, 1'b0);
        send_pixel(16'd6000, 1'b0);
    endtask

    // Shrink a dimension below the current position: that position ends
    // its row or frame and the counter wraps.
    task automatic test_counter_past_dimension();
        wait_drained();
        cfg_write(REG_IMAGE_WIDTH,  32'd8);
        cfg_write(REG_IMAGE_HEIGHT, 32'd8);
        cfg_write(REG_CENTER_X,     32'd1024);
        cfg_write(REG_CENTER_Y,     32'd512);
        send_pixel(16'd100, 1'b1);
        send_pixel(16'd200, 1'b0);
        send_pixel(16'd300, 1'b0);
        send_pixel(16'd400, 1'b0);
        wait_drained();
        cfg_write(REG_IMAGE_WIDTH, 32'd3);
        send_pixel(16'd500, 1'b0);
        send_pixel(16'd600, 1'b0);
        wait_drained();
        cfg_write(REG_IMAGE_WIDTH, 32'd1);
        send_pixel(16'd700, 1'b0);
        send_pixel(16'd800, 1'b0);
        wait_drained();
        cfg_write(REG_IMAGE_HEIGHT, 32'd2);
        send_pixel(16'd900, 1'b0);
    endtask

    // Writes past the last register change nothing
    task automatic test_unmapped_registers();
        wait_drained();
        cfg_write(REG_SPARE_LO, $urandom);
        cfg_write(REG_SPARE_HI, $urandom);
        check_registers();
    endtask

    task automatic test_random_frames(input int total);
        int done;
        int n;
        done = 0;
        while (done < total) begin
            wait_drained();
            load_random_config();
            tx_gap_pct   = 20 * $urandom_range(0, 3);
            rx_stall_pct = 20 * $urandom_range(0, 3);
            n = $urandom_range(60, 140);
            if (n > total - done) n = total - done;
            stream_frames(n, 0);
            done += n;
        end
    endtask

    // One tall single-column frame with deep pixels drives y into
    // positive saturation on the lower rows.
    task automatic test_tall_column(input int total);
        wait_drained();
        cfg_write(REG_IMAGE_WIDTH,  32'd1);
        cfg_write(REG_IMAGE_HEIGHT, 32'(total));
        cfg_write(REG_CENTER_X,     $urandom);
        cfg_write(REG_CENTER_Y,     32'($urandom_range(0, 1023)));
        cfg_write(REG_INV_FOCAL_X,  32'($urandom_range(24'hA0_0000, 24'hFF_FFFF)));
        cfg_write(REG_INV_FOCAL_Y,  32'($urandom_range(24'hA0_0000, 24'hFF_FFFF)));
        tx_gap_pct   = 15;
        rx_stall_pct = 15;
        stream_frames(total, 50000);
    endtask

    task automatic test_steady_stream(input int total);
        wait_drained();
        load_random_config();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        stream_frames(total, 0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        int waited;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_pixel      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cfg_width    = RST_IMAGE_WIDTH;
        cfg_height   = RST_IMAGE_HEIGHT;
        cfg_center_x = RST_CENTER_X;
        cfg_center_y = RST_CENTER_Y;
        cfg_inv_x    = RST_INV_FOCAL_X;
        cfg_inv_y    = RST_INV_FOCAL_Y;
        col_pos      = 0;
        row_pos      = 0;
        tx_gap_pct   = 25;
        rx_stall_pct = 25;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_saturation_and_zero_focal();
        test_dimension_clamp();
        test_counter_past_dimension();
        test_unmapped_registers();
        test_random_frames(860);
        test_tall_column(240);
        test_steady_stream(250);

        // Drain the tail and let stray points show up
        i_valid <= 1'b0;
        waited = 0;
        while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_points.size() != 0) begin
            report_error($sformatf("%0d points never arrived", expected_points.size()));
        end

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
